// ===== hdl/lil_pkg.sv =====
// ----------------------------------------------------------------------------
// lil_pkg: shared types and codes for the live interval list
// Holds the store depth, operation and status codes, and the query token
// that travels down the row of segment cells.
// ----------------------------------------------------------------------------
package lil_pkg;

  // store depth and the width of a count or position into it
  localparam int MAX_SEGMENTS = 64;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  // operation kinds
  localparam logic [2:0] KIND_ADD         = 3'd0;
  localparam logic [2:0] KIND_POINT       = 3'd1;
  localparam logic [2:0] KIND_CONTAINS    = 3'd2;
  localparam logic [2:0] KIND_TRIM        = 3'd3;
  localparam logic [2:0] KIND_ENDS_BEFORE = 3'd4;

  // add status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  // token handed from cell to cell, one transaction at a time
  typedef struct packed {
    logic [2:0]        kind;
    logic signed [31:0] point;     // query point, trim bound or add start
    logic signed [31:0] endp;      // add end
    logic              dest;       // destination use: end counts as outside
    logic              wr_app;     // add appends a new segment
    logic              wr_mrg;     // add extends the last segment
    logic              done;       // walk has settled
    logic              hit;
    logic [1:0]        status;
    logic [CNT_W-1:0]  cnt_left;   // valid segments still ahead, this cell included
    logic [CNT_W-1:0]  skip_left;  // leading segments to pass over
    logic [CNT_W-1:0]  adv;        // trim advance gathered so far
  } tok_t;

endpackage

// ===== hdl/lil_cell.sv =====
// ----------------------------------------------------------------------------
// lil_cell: one segment slot of the live interval list
// Stores one [start,end) segment, evaluates the passing token against it
// and hands the updated token to the next cell through a register.
// ----------------------------------------------------------------------------
module lil_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_in,
  input  lil_pkg::tok_t tok_in,
  output logic          vld_out,
  output lil_pkg::tok_t tok_out
);

  logic signed [31:0] seg_start_r, seg_start_nxt;
  logic signed [31:0] seg_end_r, seg_end_nxt;
  logic               vld_r;
  lil_pkg::tok_t      tok_r, tok_nxt;
  logic               here;
  logic               skip;

  // evaluate the token against the stored segment
  always_comb begin
    seg_start_nxt = seg_start_r;
    seg_end_nxt   = seg_end_r;
    tok_nxt       = tok_in;
    here          = (tok_in.cnt_left != '0);
    skip          = (tok_in.skip_left != '0);
    if (vld_in) begin
      unique case (tok_in.kind)
        lil_pkg::KIND_ADD: begin
          if (tok_in.wr_app && !tok_in.done && !here) begin
            seg_start_nxt = tok_in.point;
            seg_end_nxt   = tok_in.endp;
            tok_nxt.done  = 1'b1;
          end
          if (tok_in.wr_mrg && tok_in.cnt_left == lil_pkg::CNT_W'(1)) begin
            seg_end_nxt = tok_in.endp;
          end
        end
        lil_pkg::KIND_POINT: begin
          if (here && !tok_in.done && !skip) begin
            if (tok_in.point < seg_start_r) begin
              tok_nxt.done = 1'b1;
            end else if (tok_in.point < seg_end_r) begin
              tok_nxt.done = 1'b1;
              tok_nxt.hit  = 1'b1;
            end
          end
        end
        lil_pkg::KIND_CONTAINS: begin
          if (here && seg_start_r <= tok_in.point &&
              (tok_in.point < seg_end_r ||
               (!tok_in.dest && tok_in.point == seg_end_r))) begin
            tok_nxt.hit = 1'b1;
          end
        end
        lil_pkg::KIND_TRIM: begin
          if (here && !tok_in.done && !skip) begin
            if (seg_end_r <= tok_in.point) begin
              tok_nxt.adv = tok_in.adv + lil_pkg::CNT_W'(1);
            end else begin
              tok_nxt.done = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      // advance the position counters past this cell
      if (here) tok_nxt.cnt_left = tok_in.cnt_left - lil_pkg::CNT_W'(1);
      if (skip) tok_nxt.skip_left = tok_in.skip_left - lil_pkg::CNT_W'(1);
    end
  end

  // hold the segment
  always_ff @(posedge clk) begin
    seg_start_r <= seg_start_nxt;
    seg_end_r   <= seg_end_nxt;
  end

  // pass the token on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign vld_out = vld_r;
  assign tok_out = tok_r;

endmodule

// ===== hdl/live_interval_list_unit.sv =====
// ----------------------------------------------------------------------------
// live_interval_list_unit: sorted list of live segments with point queries
// Keeps up to MAX_SEGMENTS half-open segments and answers add, point,
// contains, trim and ends-before requests, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: in_tuser carries the operation kind, in_tdata the
//   start point, end point and the use_trimmed, is_dest and other_empty
//   flags. Output channel out_*: out_tdata carries hit and status.
//   Each transaction sends a token down a row of MAX_SEGMENTS cells, one
//   cell per cycle; the block takes one request at a time and takes no
//   new one until the previous result has left the row of cells.
//   A new request is taken while the previous result still waits in the
//   output register. If the receiver stalls, a finished result is parked
//   in a holding register and no further request is taken until it moves
//   to the output.
//   Reset (rst_n low, synchronous) empties the list, clears the trim
//   position and drops any request in flight. Stored segment contents
//   are not cleared; only entries below the segment count are ever used.
// ----------------------------------------------------------------------------
module live_interval_list_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [31:0] start_point, [63:32] end_point,
                                  // [64] use_trimmed, [65] is_dest,
                                  // [66] other_empty, [71:67] zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] hit, [2:1] status, [7:3] zero
);

  localparam int N = lil_pkg::MAX_SEGMENTS;
  localparam int W = lil_pkg::CNT_W;

  logic               accept;
  logic               busy_r, busy_nxt;
  logic               hold_vld_r, hold_vld_nxt;
  logic [2:0]         hold_res_r, hold_res_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [2:0]         out_res_r, out_res_nxt;
  logic [W-1:0]       count_r, count_nxt;
  logic [W-1:0]       trim_r, trim_nxt;
  logic signed [31:0] last_end_r, last_end_nxt;
  logic signed [31:0] sp, ep;
  logic               use_trimmed, is_dest, other_empty;
  logic [2:0]         kind;
  lil_pkg::tok_t      entry_tok;
  logic               out_free;
  logic [N:0]         chain_vld;
  lil_pkg::tok_t      chain_tok [0:N];

  assign kind        = in_tuser;
  assign sp          = $signed(in_tdata[31:0]);
  assign ep          = $signed(in_tdata[63:32]);
  assign use_trimmed = in_tdata[64];
  assign is_dest     = in_tdata[65];
  assign other_empty = in_tdata[66];

  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  // build the entry token and update list bookkeeping on accept
  always_comb begin
    entry_tok           = '0;
    entry_tok.kind      = kind;
    entry_tok.point     = sp;
    entry_tok.endp      = ep;
    entry_tok.dest      = is_dest;
    entry_tok.cnt_left  = count_r;
    entry_tok.status    = lil_pkg::ST_OK;
    count_nxt           = count_r;
    last_end_nxt        = last_end_r;
    unique case (kind)
      lil_pkg::KIND_ADD: begin
        if (count_r != '0 && sp < last_end_r) begin
          entry_tok.status = lil_pkg::ST_ORDER;
        end else if (count_r != '0 && sp == last_end_r) begin
          entry_tok.wr_mrg = 1'b1;
          last_end_nxt     = ep;
        end else if (count_r == W'(N)) begin
          entry_tok.status = lil_pkg::ST_FULL;
        end else begin
          entry_tok.wr_app = 1'b1;
          count_nxt        = count_r + W'(1);
          last_end_nxt     = ep;
        end
      end
      lil_pkg::KIND_POINT: begin
        entry_tok.skip_left = use_trimmed ? trim_r : '0;
      end
      lil_pkg::KIND_TRIM: begin
        entry_tok.skip_left = trim_r;
      end
      lil_pkg::KIND_ENDS_BEFORE: begin
        entry_tok.hit = (count_r == '0) || other_empty || (last_end_r <= sp);
      end
      default: begin
      end
    endcase
    if (!accept) begin
      count_nxt    = count_r;
      last_end_nxt = last_end_r;
    end
  end

  // row of segment cells
  assign chain_vld[0] = accept;
  assign chain_tok[0] = entry_tok;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lil_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (chain_vld[g]),
      .tok_in  (chain_tok[g]),
      .vld_out (chain_vld[g+1]),
      .tok_out (chain_tok[g+1])
    );
  end

  // collect the result at the end of the row and drive the output
  always_comb begin
    busy_nxt     = busy_r;
    hold_vld_nxt = hold_vld_r;
    hold_res_nxt = hold_res_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_res_nxt  = out_res_r;
    trim_nxt     = trim_r;
    if (accept) busy_nxt = 1'b1;
    if (chain_vld[N]) begin
      trim_nxt = trim_r + chain_tok[N].adv;
      if (out_free) begin
        out_vld_nxt = 1'b1;
        out_res_nxt = {chain_tok[N].status, chain_tok[N].hit};
        busy_nxt    = 1'b0;
      end else begin
        hold_vld_nxt = 1'b1;
        hold_res_nxt = {chain_tok[N].status, chain_tok[N].hit};
      end
    end else if (hold_vld_r && out_free) begin
      out_vld_nxt  = 1'b1;
      out_res_nxt  = hold_res_r;
      hold_vld_nxt = 1'b0;
      busy_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      count_r    <= '0;
      trim_r     <= '0;
    end else begin
      busy_r     <= busy_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      count_r    <= count_nxt;
      trim_r     <= trim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_res_r <= hold_res_nxt;
    out_res_r  <= out_res_nxt;
    last_end_r <= last_end_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_res_r};

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= W'(N))
    else $error("segment count above store depth");

  a_trim_range: assert property (@(posedge clk) disable iff (!rst_n)
    trim_r <= count_r)
    else $error("trim position beyond segment count");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld))
    else $error("more than one token in the cell row");

  a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chain_vld[N] |-> busy_r && !hold_vld_r)
    else $error("token left the row while no request was open");

  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> busy_r && out_vld_r)
    else $error("parked result without a stalled output");

endmodule
